>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the histogram RTL. Define NO_ASSERTIONS to drop
// them. Both macros expect clk in scope; PHA_ASSERT also expects arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked out of reset only
`define PHA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PHA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PHA_ASSERT(label, prop, msg)

`define PHA_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> hdl/pha_pkg.sv
// ----------------------------------------------------------------------------
// pha_pkg
// Widths, grid size, codes and shared types of the position histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pha_pkg;

	// grid
	localparam int BINS_X   = 16;
	localparam int BINS_Y   = 16;
	localparam int BINS_Z   = 16;
	localparam int GROUPS   = 3;
	localparam int BINS_XY  = (BINS_X > BINS_Y) ? BINS_X : BINS_Y;
	localparam int BINS_MAX = (BINS_XY > BINS_Z) ? BINS_XY : BINS_Z;
	localparam int BIN_W    = $clog2(BINS_MAX);
	localparam int N_W      = BIN_W + 1;
	localparam int ROWS     = BINS_X * BINS_Y * BINS_Z;
	localparam int ROW_W    = $clog2(ROWS);

	// field widths
	localparam int POS_W   = 32;
	localparam int SPD_W   = 32;
	localparam int CNT_W   = 32;
	localparam int SUM_W   = 64;
	localparam int RIDX_W  = 4;
	localparam int GRP_W   = 2;
	localparam int SCALE_W = 48;

	// binning arithmetic: scale split in two halves, product reduced by 2^(FRAC-1)
	localparam int FRAC_W  = 40;
	localparam int HALF_W  = SCALE_W / 2;
	localparam int PROD_W  = POS_W + HALF_W;
	localparam int MID_W   = PROD_W + 1;
	localparam int SHIFT   = FRAC_W - 1 - HALF_W;
	localparam int Q_W     = MID_W - SHIFT;

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1099511);

	// operation codes
	localparam logic OP_ACC  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// group codes
	localparam logic [GRP_W-1:0] GRP_ALL = 2'd0;
	localparam logic [GRP_W-1:0] GRP_SP0 = 2'd1;
	localparam logic [GRP_W-1:0] GRP_SP1 = 2'd2;

	// axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef logic [GROUPS-1:0][CNT_W-1:0] cnt_row_t;
	typedef logic [GROUPS-1:0][SUM_W-1:0] sum_row_t;

	// binning lane stage enables
	typedef struct packed {
		logic mul;
		logic mid;
	} pha_step_t;

	// store request: fetch a row, or write back the updated fetched row
	typedef struct packed {
		logic             rd;
		logic             upd;
		logic [ROW_W-1:0] addr;
		logic             species;
		logic [SPD_W-1:0] speed;
	} pha_store_cmd_t;

	function automatic int axis_bins(input logic [1:0] axis);
		unique case (axis)
			AXIS_Y:  return BINS_Y;
			AXIS_Z:  return BINS_Z;
			default: return BINS_X;
		endcase
	endfunction

	function automatic logic [ROW_W-1:0] row_of(input logic [BIN_W-1:0] x,
			input logic [BIN_W-1:0] y, input logic [BIN_W-1:0] z);
		return ROW_W'(x) * ROW_W'(BINS_Y * BINS_Z) + ROW_W'(y) * ROW_W'(BINS_Z)
			+ ROW_W'(z);
	endfunction

endpackage

>>> hdl/pha_if.sv
// ----------------------------------------------------------------------------
// pha_if
// Valid/ready channels of the histogram: samples in, results out, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pha_in_if import pha_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    op;
	logic                    species;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic [SPD_W-1:0]        speed_sq;
	logic [RIDX_W-1:0]       read_x;
	logic [RIDX_W-1:0]       read_y;
	logic [RIDX_W-1:0]       read_z;
	logic [GRP_W-1:0]        read_group;

	modport source (output valid, op, species, pos_x, pos_y, pos_z, speed_sq,
		read_x, read_y, read_z, read_group, input ready);
	modport sink (input valid, op, species, pos_x, pos_y, pos_z, speed_sq,
		read_x, read_y, read_z, read_group, output ready);
endinterface

interface pha_out_if import pha_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             accepted;
	logic [CNT_W-1:0] count_value;
	logic [SUM_W-1:0] sum_value;

	modport source (output valid, accepted, count_value, sum_value, input ready);
	modport sink (input valid, accepted, count_value, sum_value, output ready);
endinterface

interface pha_cfg_if import pha_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SCALE_W-1:0] bin_scale;

	modport source (output valid, bin_scale, input ready);
	modport sink (input valid, bin_scale, output ready);
endinterface

>>> hdl/pha_axis_bin.sv
// ----------------------------------------------------------------------------
// pha_axis_bin
// One binning lane: floor(pos * scale + n/2), with the 1..n-1 window check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pha_axis_bin import pha_pkg::*; (
	input  logic                    clk,
	input  logic [1:0]              axis,
	input  pha_step_t               step,
	input  logic signed [POS_W-1:0] pos,
	input  logic [SCALE_W-1:0]      scale,
	output logic [BIN_W-1:0]        bin,
	output logic                    hit
);

	logic [N_W-1:0]    n;
	logic [POS_W-1:0]  mag;
	logic [MID_W-1:0]  mid;
	logic [Q_W-1:0]    q;
	logic              exact;
	logic              win_ok;
	logic [N_W-1:0]    u;

	logic              neg_s1;
	logic [PROD_W-1:0] a_s1;
	logic [PROD_W-1:0] b_s1;

	logic              neg_s2;
	logic              inexact_s2;
	logic [BIN_W-1:0]  low_s2;
	logic              hit_s2;

	assign n   = N_W'(axis_bins(axis));
	assign mag = pos[POS_W-1] ? (~POS_W'(pos) + 1'b1) : POS_W'(pos);

	// stage 1: two 32x24 partial products
	always_ff @(posedge clk) begin
		if (step.mul) begin
			neg_s1 <= pos[POS_W-1];
			a_s1   <= PROD_W'(mag) * PROD_W'(scale[SCALE_W-1:HALF_W]);
			b_s1   <= PROD_W'(mag) * PROD_W'(scale[HALF_W-1:0]);
		end
	end

	// q = floor(|pos| * scale / 2^39), i.e. twice the offset from the centre
	always_comb begin
		mid   = MID_W'(a_s1) + MID_W'(b_s1[PROD_W-1:HALF_W]);
		q     = mid[MID_W-1:SHIFT];
		exact = (b_s1[HALF_W-1:0] == '0) && (mid[SHIFT-1:0] == '0);
		// negative side floors one further down when bits were lost
		if (neg_s1)
			win_ok = exact ? (q < Q_W'(n - 1'b1)) : (q < Q_W'(n - 2'd2));
		else
			win_ok = q < Q_W'(n);
	end

	// stage 2: window decision and the few low bits needed for the bin
	always_ff @(posedge clk) begin
		if (step.mid) begin
			neg_s2     <= neg_s1;
			inexact_s2 <= !exact;
			low_s2     <= q[BIN_W-1:0];
			hit_s2     <= win_ok;
		end
	end

	assign u   = neg_s2 ? (n - N_W'(low_s2) - N_W'(inexact_s2)) : (n + N_W'(low_s2));
	assign bin = u[BIN_W:1];
	assign hit = hit_s2;

endmodule

>>> hdl/pha_store.sv
// ----------------------------------------------------------------------------
// pha_store
// Count and sum memories, one row per bin holding all groups, with the
// saturating update and the clearing sweep after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pha_store import pha_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  pha_store_cmd_t cmd,
	output cnt_row_t       rd_count,
	output sum_row_t       rd_sum,
	output logic           busy
);

	cnt_row_t count_mem [ROWS];
	sum_row_t sum_mem [ROWS];

	logic             busy_q;
	logic [ROW_W-1:0] clr_addr_q;
	logic [ROW_W-1:0] addr_q;
	cnt_row_t         rd_count_q;
	sum_row_t         rd_sum_q;

	logic [GROUPS-1:0]            grp_hit;
	logic [GROUPS-1:0][SUM_W:0]   sum_wide;
	cnt_row_t                     new_count;
	sum_row_t                     new_sum;
	logic                         wr_en;
	logic [ROW_W-1:0]             wr_addr;
	cnt_row_t                     wr_count;
	sum_row_t                     wr_sum;

	// total group always, plus the sample's species group
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_hit[g]  = (g == int'(GRP_ALL)) || (g == int'(GRP_SP0) + int'(cmd.species));
			sum_wide[g] = {1'b0, rd_sum_q[g]} + (SUM_W + 1)'(cmd.speed);
			new_count[g] = rd_count_q[g];
			new_sum[g]   = rd_sum_q[g];
			if (grp_hit[g]) begin
				if (rd_count_q[g] != '1)
					new_count[g] = rd_count_q[g] + 1'b1;
				new_sum[g] = sum_wide[g][SUM_W] ? '1 : sum_wide[g][SUM_W-1:0];
			end
		end
	end

	always_comb begin
		wr_en    = busy_q || cmd.upd;
		wr_addr  = busy_q ? clr_addr_q : addr_q;
		wr_count = busy_q ? '0 : new_count;
		wr_sum   = busy_q ? '0 : new_sum;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			count_mem[wr_addr] <= wr_count;
			sum_mem[wr_addr]   <= wr_sum;
		end
		if (cmd.rd) begin
			rd_count_q <= count_mem[cmd.addr];
			rd_sum_q   <= sum_mem[cmd.addr];
			addr_q     <= cmd.addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			if (clr_addr_q == ROW_W'(ROWS - 1))
				busy_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign rd_count = rd_count_q;
	assign rd_sum   = rd_sum_q;
	assign busy     = busy_q;

	`PHA_ASSERT(a_no_fetch_while_clearing, cmd.rd |-> !busy_q, "row fetch during clear sweep")
	`PHA_ASSERT(a_no_update_while_clearing, cmd.upd |-> !busy_q, "write-back during clear sweep")
	`PHA_ASSERT(a_clear_runs_once, !busy_q |=> !busy_q, "clear sweep restarted")
	`PHA_ASSERT(a_total_never_wraps, cmd.upd |-> (new_count[GRP_ALL] != '0), "count wrapped")
	`PHA_ASSERT_ALWAYS(a_no_fetch_in_reset, !arst_n |-> !cmd.rd, "row fetch in reset")

endmodule

>>> hdl/position_histogram_accumulator_core.sv
// ----------------------------------------------------------------------------
// position_histogram_accumulator_core
// 3-D position histogram with per-bin sample count and speed-squared sum.
// ----------------------------------------------------------------------------
// Each sample beat is binned on x, y and z as floor(pos * bin_scale + BINS/2)
// and, when every axis lands in bins 1..BINS-1, adds one to the count and
// speed_sq to the sum of that bin in the all-particles group and in the
// sample's species group; both saturate at full scale. A read beat returns
// count and sum of one bin of one group (accepted 0 and zeros for a bad
// group or index). Every sample beat gives exactly one result beat. One item
// is in flight at a time and passes in order through the binning lanes
// (split 32x24 multiply, then the carry add and window compare), the
// step that forms the row address and fetches the row, the update and
// write-back of the row, and the result register; a new sample is taken
// only once the item has left the update stage. A stalled result holds
// the item in the update stage until the result register frees.
// After reset the stores are swept to zero, one row per cycle, over all
// BINS_X*BINS_Y*BINS_Z = 4096 rows of the grid, and no
// sample is taken until then; bin_scale may be written at any time the block
// is idle once reset is released, the clearing sweep included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module position_histogram_accumulator_core import pha_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	pha_cfg_if.sink      cfg,
	pha_in_if.sink       sample,
	pha_out_if.source    result
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_MID  = 3'd2;
	localparam logic [2:0] ST_BIN  = 3'd3;
	localparam logic [2:0] ST_MOD  = 3'd4;

	logic [2:0]         state_q;
	logic [SCALE_W-1:0] bin_scale_q;
	logic               cfg_ready_q;

	// held item
	logic                    op_q;
	logic                    species_q;
	logic signed [POS_W-1:0] pos_x_q;
	logic signed [POS_W-1:0] pos_y_q;
	logic signed [POS_W-1:0] pos_z_q;
	logic [SPD_W-1:0]        speed_q;
	logic [RIDX_W-1:0]       read_x_q;
	logic [RIDX_W-1:0]       read_y_q;
	logic [RIDX_W-1:0]       read_z_q;
	logic [GRP_W-1:0]        read_group_q;

	// row fetched for this item (accepted sample or valid read)
	logic live_q;

	// result register
	logic             out_valid_q;
	logic             accepted_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;

	logic             in_fire;
	logic             advance;
	logic             store_busy;
	pha_step_t        step;
	pha_store_cmd_t   st_cmd;
	cnt_row_t         row_count;
	sum_row_t         row_sum;
	logic [BIN_W-1:0] bin_x, bin_y, bin_z;
	logic             hit_x, hit_y, hit_z;
	logic             read_ok;
	logic             fetch;
	logic [ROW_W-1:0] acc_row;
	logic [ROW_W-1:0] read_row;
	logic [CNT_W-1:0] sel_count;
	logic [SUM_W-1:0] sel_sum;

	// config port refuses beats while reset holds the register
	assign cfg.ready    = cfg_ready_q;
	assign sample.ready = (state_q == ST_IDLE) && !store_busy;
	assign in_fire      = sample.valid && sample.ready;

	// result leaves the update stage when the output register is free or draining
	assign advance = (state_q == ST_MOD) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ready_q <= 1'b0;
		end else begin
			cfg_ready_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_scale_q <= SCALE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			bin_scale_q <= cfg.bin_scale;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q         <= sample.op;
			species_q    <= sample.species;
			pos_x_q      <= sample.pos_x;
			pos_y_q      <= sample.pos_y;
			pos_z_q      <= sample.pos_z;
			speed_q      <= sample.speed_sq;
			read_x_q     <= sample.read_x;
			read_y_q     <= sample.read_y;
			read_z_q     <= sample.read_z;
			read_group_q <= sample.read_group;
		end
	end

	// ---- binning lanes, one per axis ----
	assign step.mul = (state_q == ST_MUL);
	assign step.mid = (state_q == ST_MID);

	pha_axis_bin u_bin_x (
		.clk   (clk),
		.axis  (AXIS_X),
		.step  (step),
		.pos   (pos_x_q),
		.scale (bin_scale_q),
		.bin   (bin_x),
		.hit   (hit_x)
	);

	pha_axis_bin u_bin_y (
		.clk   (clk),
		.axis  (AXIS_Y),
		.step  (step),
		.pos   (pos_y_q),
		.scale (bin_scale_q),
		.bin   (bin_y),
		.hit   (hit_y)
	);

	pha_axis_bin u_bin_z (
		.clk   (clk),
		.axis  (AXIS_Z),
		.step  (step),
		.pos   (pos_z_q),
		.scale (bin_scale_q),
		.bin   (bin_z),
		.hit   (hit_z)
	);

	// ---- row address and fetch decision ----
	// a read index past the grid, or group code 3, is answered without a fetch
	assign read_ok = (read_group_q == GRP_ALL || read_group_q == GRP_SP0
		|| read_group_q == GRP_SP1)
		&& (32'(read_x_q) < BINS_X) && (32'(read_y_q) < BINS_Y) && (32'(read_z_q) < BINS_Z);

	assign acc_row  = row_of(bin_x, bin_y, bin_z);
	assign read_row = row_of(BIN_W'(read_x_q), BIN_W'(read_y_q), BIN_W'(read_z_q));
	assign fetch    = (op_q == OP_READ) ? read_ok : (hit_x && hit_y && hit_z);

	always_comb begin
		st_cmd.rd      = (state_q == ST_BIN) && fetch;
		st_cmd.upd     = advance && live_q && (op_q == OP_ACC);
		st_cmd.addr    = (op_q == OP_READ) ? read_row : acc_row;
		st_cmd.species = species_q;
		st_cmd.speed   = speed_q;
	end

	pha_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (st_cmd),
		.rd_count (row_count),
		.rd_sum   (row_sum),
		.busy     (store_busy)
	);

	// ---- read-out group select ----
	always_comb begin
		sel_count = '0;
		sel_sum   = '0;
		case (read_group_q)
			GRP_ALL: begin
				sel_count = row_count[GRP_ALL];
				sel_sum   = row_sum[GRP_ALL];
			end
			GRP_SP0: begin
				sel_count = row_count[GRP_SP0];
				sel_sum   = row_sum[GRP_SP0];
			end
			GRP_SP1: begin
				sel_count = row_count[GRP_SP1];
				sel_sum   = row_sum[GRP_SP1];
			end
			default: begin
				sel_count = '0;
				sel_sum   = '0;
			end
		endcase
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			live_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_MID;
				end
				ST_MID: begin
					state_q <= ST_BIN;
				end
				ST_BIN: begin
					live_q  <= fetch;
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (advance)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			accepted_q <= live_q;
			count_q    <= (live_q && op_q == OP_READ) ? sel_count : '0;
			sum_q      <= (live_q && op_q == OP_READ) ? sel_sum : '0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.accepted    = accepted_q;
	assign result.count_value = count_q;
	assign result.sum_value   = sum_q;

	`PHA_ASSERT(a_item_reaches_update, in_fire |-> ##4 (state_q == ST_MOD), "item did not reach update")
	`PHA_ASSERT(a_fetch_then_update, st_cmd.rd |=> (state_q == ST_MOD), "fetch not followed by update")
	`PHA_ASSERT(a_drop_gives_zero, (result.valid && !result.accepted) |-> (result.count_value == '0 && result.sum_value == '0), "dropped item with data")

endmodule
